[rtl/fuzzy_membership_evaluator_macros.svh]
// Assertion macros for the fuzzy membership evaluator.
// They use the clk and arst_n names of the module that includes them.
`ifndef FUZZY_MEMBERSHIP_EVALUATOR_MACROS_SVH
`define FUZZY_MEMBERSHIP_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FME_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fuzzy membership evaluator check failed");
`define FME_ASSERT_DLY(name, ante, dly, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("fuzzy membership evaluator latency check failed");
`else
`define FME_ASSERT_IMP(name, ante, cons)
`define FME_ASSERT_DLY(name, ante, dly, cons)
`endif
`endif

[rtl/fme_pkg.sv]
package fme_pkg;

	localparam int HEIGHT_W = 16;
	localparam int SHAPE_W = 2;
	localparam int INDEX_W = 3;

	localparam logic [SHAPE_W-1:0] SHAPE_RECT = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_TRI = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_TRAP = 2'd2;

	localparam logic [INDEX_W-1:0] REG_SHAPE = 3'd0;
	localparam logic [INDEX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [INDEX_W-1:0] REG_POINT_A = 3'd2;
	localparam logic [INDEX_W-1:0] REG_POINT_B = 3'd3;
	localparam logic [INDEX_W-1:0] REG_POINT_C = 3'd4;
	localparam logic [INDEX_W-1:0] REG_POINT_D = 3'd5;
	localparam logic [INDEX_W-1:0] REG_OPEN_LEFT = 3'd6;
	localparam logic [INDEX_W-1:0] REG_OPEN_RIGHT = 3'd7;

	localparam logic [SHAPE_W-1:0] SHAPE_RESET = SHAPE_TRI;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'h8000;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_ONE,
		KIND_RATIO
	} kind_t;

	typedef struct packed {
		logic [SHAPE_W-1:0] shape;
		logic open_left;
		logic open_right;
	} cfg_ctl_t;

endpackage

[rtl/fme_classify.sv]
module fme_classify
	import fme_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic signed [SAMPLE_WIDTH-1:0] sample,
	input logic signed [SAMPLE_WIDTH-1:0] point_a,
	input logic signed [SAMPLE_WIDTH-1:0] point_b,
	input logic signed [SAMPLE_WIDTH-1:0] point_c,
	input logic signed [SAMPLE_WIDTH-1:0] point_d,
	input cfg_ctl_t ctl,
	output logic out_valid,
	output kind_t out_kind,
	output logic [SAMPLE_WIDTH-1:0] out_rem,
	output logic [SAMPLE_WIDTH-1:0] out_width
);

	localparam int DW = SAMPLE_WIDTH + 1;

	typedef enum logic [1:0] {
		SIDE_LEFT,
		SIDE_TRI_RIGHT,
		SIDE_TRAP_RIGHT
	} side_t;

	side_t side;
	kind_t kind_c;
	logic out_low;
	logic out_high_c;
	logic out_high_d;
	logic signed [SAMPLE_WIDTH-1:0] op_p;
	logic signed [SAMPLE_WIDTH-1:0] op_q;
	logic signed [SAMPLE_WIDTH-1:0] op_r;
	logic signed [SAMPLE_WIDTH-1:0] op_s;
	logic signed [DW-1:0] dist_c;
	logic signed [DW-1:0] width_c;

	logic valid_s1;
	kind_t kind_s1;
	logic signed [DW-1:0] dist_s1;
	logic signed [DW-1:0] width_s1;

	kind_t kind2_c;
	logic valid_s2;
	kind_t kind_s2;
	logic [SAMPLE_WIDTH-1:0] rem_s2;
	logic [SAMPLE_WIDTH-1:0] width_s2;

	always_comb begin
		out_low = !ctl.open_left && (sample < point_a);
		out_high_c = !ctl.open_right && (sample > point_c);
		out_high_d = !ctl.open_right && (sample > point_d);
		kind_c = KIND_ZERO;
		side = SIDE_LEFT;
		unique case (ctl.shape)
			SHAPE_RECT: begin
				kind_c = (out_low || out_high_d) ? KIND_ZERO : KIND_ONE;
			end
			SHAPE_TRI: begin
				if (out_low || out_high_c) begin
					kind_c = KIND_ZERO;
				end else if (sample == point_b) begin
					kind_c = KIND_ONE;
				end else if (sample < point_b) begin
					kind_c = ctl.open_left ? KIND_ONE : KIND_RATIO;
					side = SIDE_LEFT;
				end else begin
					kind_c = ctl.open_right ? KIND_ONE : KIND_RATIO;
					side = SIDE_TRI_RIGHT;
				end
			end
			SHAPE_TRAP: begin
				if (out_low || out_high_d) begin
					kind_c = KIND_ZERO;
				end else if (sample < point_b) begin
					kind_c = ctl.open_left ? KIND_ONE : KIND_RATIO;
					side = SIDE_LEFT;
				end else if (sample < point_c) begin
					kind_c = KIND_ONE;
				end else if (sample < point_d) begin
					kind_c = ctl.open_right ? KIND_ONE : KIND_RATIO;
					side = SIDE_TRAP_RIGHT;
				end else begin
					kind_c = ctl.open_right ? KIND_ONE : KIND_ZERO;
				end
			end
			default: begin
				kind_c = KIND_ZERO;
			end
		endcase
	end

	always_comb begin
		unique case (side)
			SIDE_TRI_RIGHT: begin
				op_p = point_c;
				op_q = sample;
				op_r = point_c;
				op_s = point_b;
			end
			SIDE_TRAP_RIGHT: begin
				op_p = point_d;
				op_q = sample;
				op_r = point_d;
				op_s = point_c;
			end
			default: begin
				op_p = sample;
				op_q = point_a;
				op_r = point_b;
				op_s = point_a;
			end
		endcase
		dist_c = DW'(op_p) - DW'(op_q);
		width_c = DW'(op_r) - DW'(op_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_c;
		dist_s1 <= dist_c;
		width_s1 <= width_c;
	end

	always_comb begin
		kind2_c = kind_s1;
		if (kind_s1 == KIND_RATIO) begin
			if (dist_s1[DW-1] || (dist_s1 == DW'(0))) begin
				kind2_c = KIND_ZERO;
			end else if (width_s1[DW-1] || (width_s1 == DW'(0))) begin
				kind2_c = KIND_ONE;
			end else if (dist_s1 >= width_s1) begin
				kind2_c = KIND_ONE;
			end else begin
				kind2_c = KIND_RATIO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind2_c;
		rem_s2 <= dist_s1[SAMPLE_WIDTH-1:0];
		width_s2 <= width_s1[SAMPLE_WIDTH-1:0];
	end

	assign out_valid = valid_s2;
	assign out_kind = kind_s2;
	assign out_rem = rem_s2;
	assign out_width = width_s2;

endmodule

[rtl/fme_divider.sv]
module fme_divider
	import fme_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int DEGREE_FRAC_BITS = 15
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input kind_t in_kind,
	input logic [SAMPLE_WIDTH-1:0] in_rem,
	input logic [SAMPLE_WIDTH-1:0] in_width,
	output logic out_valid,
	output kind_t out_kind,
	output logic [DEGREE_FRAC_BITS-1:0] out_quot
);

	localparam int STAGES = DEGREE_FRAC_BITS;

	logic valid_s [1:STAGES];
	kind_t kind_s [1:STAGES];
	logic [SAMPLE_WIDTH-1:0] rem_s [1:STAGES];
	logic [SAMPLE_WIDTH-1:0] wid_s [1:STAGES];
	logic [DEGREE_FRAC_BITS-1:0] quot_s [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic valid_in;
		kind_t kind_in;
		logic [SAMPLE_WIDTH-1:0] rem_in;
		logic [SAMPLE_WIDTH-1:0] wid_in;
		logic [DEGREE_FRAC_BITS-1:0] quot_in;
		logic [SAMPLE_WIDTH:0] shifted;
		logic ge;
		logic [SAMPLE_WIDTH:0] diff;

		if (k == 0) begin : g_head
			assign valid_in = in_valid;
			assign kind_in = in_kind;
			assign rem_in = in_rem;
			assign wid_in = in_width;
			assign quot_in = '0;
		end else begin : g_link
			assign valid_in = valid_s[k];
			assign kind_in = kind_s[k];
			assign rem_in = rem_s[k];
			assign wid_in = wid_s[k];
			assign quot_in = quot_s[k];
		end

		always_comb begin
			shifted = {rem_in, 1'b0};
			diff = shifted - {1'b0, wid_in};
			ge = shifted >= {1'b0, wid_in};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			kind_s[k+1] <= kind_in;
			wid_s[k+1] <= wid_in;
			rem_s[k+1] <= ge ? diff[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];
			quot_s[k+1] <= {quot_in[DEGREE_FRAC_BITS-2:0], ge};
		end
	end

	assign out_valid = valid_s[STAGES];
	assign out_kind = kind_s[STAGES];
	assign out_quot = quot_s[STAGES];

endmodule

[rtl/fme_scale.sv]
module fme_scale
	import fme_pkg::*;
#(
	parameter int DEGREE_FRAC_BITS = 15
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input kind_t in_kind,
	input logic [DEGREE_FRAC_BITS-1:0] in_quot,
	input logic [HEIGHT_W-1:0] height,
	output logic out_valid,
	output logic [DEGREE_FRAC_BITS:0] out_degree
);

	localparam int QW = DEGREE_FRAC_BITS + 1;
	localparam int HW = (QW > HEIGHT_W) ? QW : HEIGHT_W;
	localparam logic [QW-1:0] ONE_Q = {1'b1, {DEGREE_FRAC_BITS{1'b0}}};
	localparam logic [HW-1:0] ONE_H = HW'(ONE_Q);

	logic [QW-1:0] frac_c;
	logic [HW-1:0] height_ext;
	logic [QW-1:0] height_sat;

	logic valid_s1;
	logic [QW-1:0] frac_s1;
	logic valid_s2;
	logic [2*QW-1:0] prod_s2;

	always_comb begin
		unique case (in_kind)
			KIND_ONE: frac_c = ONE_Q;
			KIND_RATIO: frac_c = {1'b0, in_quot};
			default: frac_c = '0;
		endcase
		height_ext = HW'(height);
		height_sat = (height_ext > ONE_H) ? ONE_Q : height_ext[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		frac_s1 <= frac_c;
		prod_s2 <= (2*QW)'(height_sat) * (2*QW)'(frac_s1);
	end

	assign out_valid = valid_s2;
	assign out_degree = prod_s2[2*DEGREE_FRAC_BITS:DEGREE_FRAC_BITS];

endmodule

[rtl/fuzzy_membership_evaluator.sv]
// Channel   Handshake         Payload
// request   start, busy       sample
// result    done (strobe)     degree
// config    wr_en             wr_index, wr_data
//
// One request is taken in every cycle; busy stays low.
// A taken request passes through the classification registers, one divider
// stage per quotient bit and the scaling registers, which scale by the height
// with the multiplier registered at its output.
// Reset clears the valid bits of every stage and loads the register defaults.
// The receiver cannot stall; done is high for exactly one cycle per result.
module fuzzy_membership_evaluator
	import fme_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int DEGREE_FRAC_BITS = 15
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic done,
	output logic [DEGREE_FRAC_BITS:0] degree,
	input logic wr_en,
	input logic [INDEX_W-1:0] wr_index,
	input logic [((SAMPLE_WIDTH > HEIGHT_W) ? SAMPLE_WIDTH : HEIGHT_W)-1:0] wr_data
);

	`include "fuzzy_membership_evaluator_macros.svh"

	localparam int LAT = DEGREE_FRAC_BITS + 4;

	cfg_ctl_t ctl_q;
	logic [HEIGHT_W-1:0] height_q;
	logic signed [SAMPLE_WIDTH-1:0] point_a_q;
	logic signed [SAMPLE_WIDTH-1:0] point_b_q;
	logic signed [SAMPLE_WIDTH-1:0] point_c_q;
	logic signed [SAMPLE_WIDTH-1:0] point_d_q;

	logic cls_valid;
	kind_t cls_kind;
	logic [SAMPLE_WIDTH-1:0] cls_rem;
	logic [SAMPLE_WIDTH-1:0] cls_width;
	logic div_valid;
	kind_t div_kind;
	logic [DEGREE_FRAC_BITS-1:0] div_quot;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.shape <= SHAPE_RESET;
			ctl_q.open_left <= 1'b0;
			ctl_q.open_right <= 1'b0;
			height_q <= HEIGHT_RESET;
			point_a_q <= SAMPLE_WIDTH'(-256);
			point_b_q <= '0;
			point_c_q <= SAMPLE_WIDTH'(256);
			point_d_q <= SAMPLE_WIDTH'(256);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SHAPE: ctl_q.shape <= wr_data[SHAPE_W-1:0];
				REG_HEIGHT: height_q <= wr_data[HEIGHT_W-1:0];
				REG_POINT_A: point_a_q <= wr_data[SAMPLE_WIDTH-1:0];
				REG_POINT_B: point_b_q <= wr_data[SAMPLE_WIDTH-1:0];
				REG_POINT_C: point_c_q <= wr_data[SAMPLE_WIDTH-1:0];
				REG_POINT_D: point_d_q <= wr_data[SAMPLE_WIDTH-1:0];
				REG_OPEN_LEFT: ctl_q.open_left <= wr_data[0];
				REG_OPEN_RIGHT: ctl_q.open_right <= wr_data[0];
				default: ;
			endcase
		end
	end

	fme_classify #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_classify (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.sample(sample),
		.point_a(point_a_q),
		.point_b(point_b_q),
		.point_c(point_c_q),
		.point_d(point_d_q),
		.ctl(ctl_q),
		.out_valid(cls_valid),
		.out_kind(cls_kind),
		.out_rem(cls_rem),
		.out_width(cls_width)
	);

	fme_divider #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.DEGREE_FRAC_BITS(DEGREE_FRAC_BITS)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cls_valid),
		.in_kind(cls_kind),
		.in_rem(cls_rem),
		.in_width(cls_width),
		.out_valid(div_valid),
		.out_kind(div_kind),
		.out_quot(div_quot)
	);

	fme_scale #(
		.DEGREE_FRAC_BITS(DEGREE_FRAC_BITS)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_valid),
		.in_kind(div_kind),
		.in_quot(div_quot),
		.height(height_q),
		.out_valid(done),
		.out_degree(degree)
	);

	`FME_ASSERT_DLY(a_result_latency, start && !busy, LAT, done)
	`FME_ASSERT_IMP(a_no_spurious_result, done, $past(start && !busy, LAT))
	`FME_ASSERT_IMP(a_degree_bounded, done, !degree[DEGREE_FRAC_BITS] || (degree[DEGREE_FRAC_BITS-1:0] == '0))

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import fme_pkg::*;

	localparam int FRAC = 15;
	localparam int LATENCY = FRAC + 4;
	localparam int STALL_LIMIT = 500;
	localparam int PHASES = 24;
	localparam int PHASE_ITEMS = 68;
	localparam longint ONE = longint'(1) << FRAC;
	localparam logic [SHAPE_W-1:0] SHAPE_UNUSED = 2'd3;

	typedef struct packed {
		logic is_write;
		logic [INDEX_W-1:0] index;
		logic [15:0] value;
		logic pinned;
		logic [15:0] degree;
	} corner_step_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [15:0] degree;
	} degree_req_t;

	localparam int CORNER_ROWS = 30;
	localparam corner_step_t CORNER_STEPS [CORNER_ROWS] = '{
		'{1'b0, REG_SHAPE, 16'sd0, 1'b1, 16'd32768},
		'{1'b0, REG_SHAPE, -16'sd256, 1'b1, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd256, 1'b1, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd128, 1'b1, 16'd16384},
		'{1'b0, REG_SHAPE, 16'h8000, 1'b1, 16'd0},
		'{1'b0, REG_SHAPE, 16'h7FFF, 1'b1, 16'd0},
		'{1'b0, REG_SHAPE, -16'sd1, 1'b0, 16'd0},
		'{1'b1, REG_HEIGHT, 16'd40000, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd0, 1'b1, 16'd32768},
		'{1'b1, REG_SHAPE, {14'd0, SHAPE_UNUSED}, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd0, 1'b1, 16'd0},
		'{1'b1, REG_SHAPE, {14'd0, SHAPE_RECT}, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd256, 1'b1, 16'd32768},
		'{1'b0, REG_SHAPE, 16'sd257, 1'b1, 16'd0},
		'{1'b0, REG_SHAPE, -16'sd257, 1'b1, 16'd0},
		'{1'b1, REG_OPEN_LEFT, 16'd1, 1'b0, 16'd0},
		'{1'b1, REG_OPEN_RIGHT, 16'd1, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'h8000, 1'b1, 16'd32768},
		'{1'b0, REG_SHAPE, 16'h7FFF, 1'b1, 16'd32768},
		'{1'b1, REG_SHAPE, {14'd0, SHAPE_TRAP}, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd300, 1'b1, 16'd32768},
		'{1'b1, REG_OPEN_RIGHT, 16'd0, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd256, 1'b1, 16'd0},
		'{1'b0, REG_SHAPE, -16'sd100, 1'b1, 16'd32768},
		'{1'b1, REG_OPEN_LEFT, 16'd0, 1'b0, 16'd0},
		'{1'b1, REG_HEIGHT, 16'd16384, 1'b0, 16'd0},
		'{1'b1, REG_POINT_C, 16'sd128, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, -16'sd128, 1'b0, 16'd0},
		'{1'b0, REG_SHAPE, 16'sd100, 1'b1, 16'd16384},
		'{1'b0, REG_SHAPE, 16'sd192, 1'b0, 16'd0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] sample = '0;
	logic done;
	logic [15:0] degree;
	logic wr_en = 1'b0;
	logic [INDEX_W-1:0] wr_index = '0;
	logic [15:0] wr_data = '0;

	logic pinned_valid = 1'b0;
	logic [15:0] pinned_degree = '0;

	logic [SHAPE_W-1:0] shape_q = SHAPE_RESET;
	logic [15:0] height_q = HEIGHT_RESET;
	logic signed [15:0] pt_a = -16'sd256;
	logic signed [15:0] pt_b = 16'sd0;
	logic signed [15:0] pt_c = 16'sd256;
	logic signed [15:0] pt_d = 16'sd256;
	logic open_l = 1'b0;
	logic open_r = 1'b0;

	degree_req_t pending_degrees [$];
	int sent_count = 0;
	int got_count = 0;
	int failures = 0;
	int stall_cycles = 0;

	fuzzy_membership_evaluator uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.degree(degree),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint slope(longint gap, longint span);
		longint q;
		if (gap <= 0)
			return 0;
		if (span <= 0)
			return ONE;
		q = (gap << FRAC) / span;
		return (q > ONE) ? ONE : q;
	endfunction

	function automatic logic [15:0] predict_degree(logic signed [15:0] s);
		longint x, a, b, c, d, m, h;
		x = longint'(s);
		a = longint'(pt_a);
		b = longint'(pt_b);
		c = longint'(pt_c);
		d = longint'(pt_d);
		case (shape_q)
		SHAPE_RECT: begin
			m = ((!open_l && x < a) || (!open_r && x > d)) ? 0 : ONE;
		end
		SHAPE_TRI: begin
			if ((!open_l && x < a) || (!open_r && x > c))
				m = 0;
			else if (x == b)
				m = ONE;
			else if (x < b)
				m = open_l ? ONE : slope(x - a, b - a);
			else
				m = open_r ? ONE : slope(c - x, c - b);
		end
		SHAPE_TRAP: begin
			if ((!open_l && x < a) || (!open_r && x > d))
				m = 0;
			else if (x < b)
				m = open_l ? ONE : slope(x - a, b - a);
			else if (x < c)
				m = ONE;
			else if (x < d)
				m = open_r ? ONE : slope(d - x, d - c);
			else
				m = open_r ? ONE : 0;
		end
		default: begin
			m = 0;
		end
		endcase
		h = (height_q > ONE) ? ONE : longint'(height_q);
		return 16'((h * m) >> FRAC);
	endfunction

	always @(posedge clk) begin : degree_check
		degree_req_t want;
		if (arst_n) begin
			if (start === 1'b1 && busy === 1'b0) begin
				want.sample = sample;
				want.degree = pinned_valid ? pinned_degree : predict_degree(sample);
				pending_degrees.push_back(want);
			end
			if (done === 1'b1) begin
				if (pending_degrees.size() == 0) begin
					failures++;
					$display("%0t: degree %0d arrived with no request outstanding", $time, degree);
				end else begin
					want = pending_degrees.pop_front();
					got_count++;
					if (degree !== want.degree) begin
						failures++;
						$display("%0t: sample %0d: expected degree %0d, got %0d",
							$time, want.sample, want.degree, degree);
					end
				end
			end
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: nothing moved for %0d cycles", $time, STALL_LIMIT);
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	task automatic offer(input logic signed [15:0] s, input logic pinned,
		input logic [15:0] deg);
		start <= 1'b1;
		sample <= s;
		wr_en <= 1'b0;
		pinned_valid <= pinned;
		pinned_degree <= deg;
		do @(posedge clk); while (busy !== 1'b0);
		sent_count++;
	endtask

	task automatic settle();
		start <= 1'b0;
		if (got_count != sent_count) begin
			wait (got_count == sent_count);
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [15:0] value);
		settle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
		REG_SHAPE: shape_q = value[SHAPE_W-1:0];
		REG_HEIGHT: height_q = value;
		REG_POINT_A: pt_a = value;
		REG_POINT_B: pt_b = value;
		REG_POINT_C: pt_c = value;
		REG_POINT_D: pt_d = value;
		REG_OPEN_LEFT: open_l = value[0];
		REG_OPEN_RIGHT: open_r = value[0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	initial begin
		logic signed [15:0] pts [4];
		logic [15:0] value;
		logic signed [15:0] s;
		longint base;
		int pick;
		bit gaps_on;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < CORNER_ROWS; i++) begin
			if (CORNER_STEPS[i].is_write)
				write_reg(CORNER_STEPS[i].index, CORNER_STEPS[i].value);
			else
				offer(CORNER_STEPS[i].value, CORNER_STEPS[i].pinned, CORNER_STEPS[i].degree);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			pick = $urandom_range(0, 9);
			value = 16'($urandom);
			value[SHAPE_W-1:0] = (pick < 3) ? SHAPE_RECT : (pick < 6) ? SHAPE_TRI :
				(pick < 9) ? SHAPE_TRAP : SHAPE_UNUSED;
			write_reg(REG_SHAPE, value);

			pick = $urandom_range(0, 7);
			case (pick)
			0: value = 16'd0;
			1: value = 16'd32768;
			2: value = 16'hFFFF;
			3: value = 16'($urandom_range(32769, 65535));
			default: value = 16'($urandom_range(0, 32768));
			endcase
			write_reg(REG_HEIGHT, value);

			pick = $urandom_range(0, 9);
			if (pick == 0 || phase == 1) begin
				pts[0] = 16'h8000;
				pts[1] = 16'($urandom);
				pts[2] = 16'h7FFF;
				pts[3] = 16'h7FFF;
			end else if (pick == 1) begin
				for (int j = 0; j < 4; j++)
					pts[j] = 16'($urandom);
			end else begin
				base = longint'($urandom_range(0, 48000)) - 24000;
				for (int j = 0; j < 4; j++) begin
					pts[j] = 16'(base);
					case ($urandom_range(0, 4))
					0: base += 0;
					1: base += 1;
					2: base += longint'($urandom_range(2, 16));
					3: base += longint'($urandom_range(17, 600));
					default: base += longint'($urandom_range(601, 3000));
					endcase
					if (base > 32767)
						base = 32767;
				end
			end
			write_reg(REG_POINT_A, pts[0]);
			write_reg(REG_POINT_B, pts[1]);
			write_reg(REG_POINT_C, pts[2]);
			write_reg(REG_POINT_D, pts[3]);

			value = 16'($urandom);
			value[0] = ($urandom_range(0, 3) == 0);
			write_reg(REG_OPEN_LEFT, value);
			value = 16'($urandom);
			value[0] = ($urandom_range(0, 3) == 0);
			write_reg(REG_OPEN_RIGHT, value);

			gaps_on = (phase < PHASES - 4) && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					s = 16'(int'(pts[$urandom_range(0, 3)]) + int'($urandom_range(0, 6)) - 3);
				else if (pick < 6)
					s = 16'(int'(pts[$urandom_range(0, 3)]) + int'($urandom_range(0, 128)) - 64);
				else if (pick == 6)
					s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				else
					s = 16'($urandom);
				offer(s, 1'b0, 16'd0);
				if (k == PHASE_ITEMS / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
					settle();
				end else if (gaps_on && $urandom_range(0, 4) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
		end

		settle();
		repeat (2 * LATENCY) @(posedge clk);
		if (pending_degrees.size() != 0) begin
			failures++;
			$display("%0t: %0d requests never answered", $time, pending_degrees.size());
		end
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/fme_pkg.sv
rtl/fme_classify.sv
rtl/fme_divider.sv
rtl/fme_scale.sv
rtl/fuzzy_membership_evaluator.sv
tb/tb.sv
